>>> rtl/cqr_pkg.sv
// ----------------------------------------------------------------------------
// cqr_pkg
// Shared types and constants of the integer calculator and quadratic solver.
// ----------------------------------------------------------------------------
package cqr_pkg;

  localparam int unsigned DATA_WIDTH_DEF    = 32;
  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned PORT_WIDTH        = 32;
  localparam int unsigned OP_WIDTH          = 3;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_ROOTS = 3'd4
  } op_e;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [1:0] CNT_NONE     = 2'd0;
  localparam logic [1:0] CNT_DOUBLE   = 2'd1;
  localparam logic [1:0] CNT_DISTINCT = 2'd2;

  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic y_zero;
    logic a_zero;
    logic disc_pos;
    logic disc_zero;
  } flags_t;

  localparam int unsigned FLAGS_W = $bits(flags_t);

endpackage

>>> rtl/cqr_front.sv
// ----------------------------------------------------------------------------
// cqr_front
// Operand decode, multiplies and the exact discriminant, two register stages.
// ----------------------------------------------------------------------------
module cqr_front #(
  parameter int unsigned DW = cqr_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [cqr_pkg::OP_WIDTH-1:0]   op_i,
  input  logic [DW-1:0]                  x_i,
  input  logic [DW-1:0]                  y_i,
  input  logic [DW-1:0]                  z_i,
  output logic                           valid_o,
  output logic [cqr_pkg::OP_WIDTH-1:0]   op_o,
  output logic [DW-1:0]                  int_res_o,
  output cqr_pkg::flags_t                flags_o,
  output logic [DW-1:0]                  y_o,
  output logic [DW-1:0]                  absx_o,
  output logic [DW-1:0]                  absy_o,
  output logic [2*DW:0]                  disc_o
);

  logic signed [DW-1:0]   x, y, z;
  logic [DW-1:0]          absx, absy, absz;
  logic signed [2*DW-1:0] prod;
  logic [DW-1:0]          int_res_d;
  logic [2*DW-1:0]        b2_d, p_d;

  // stage one registers
  logic                         v1_q;
  logic [cqr_pkg::OP_WIDTH-1:0] op1_q;
  logic [DW-1:0]                res1_q, y1_q, absx1_q, absy1_q;
  logic                         xneg1_q, yneg1_q, acneg1_q;
  logic [2*DW-1:0]              b2_q, p_q;

  // stage two
  logic [2*DW+1:0]  four_p, b2w, dsum;
  logic             pos_d, zero_d;
  cqr_pkg::flags_t  flags_d;
  logic             v2_q;
  logic [cqr_pkg::OP_WIDTH-1:0] op2_q;
  logic [DW-1:0]    res2_q, y2_q, absx2_q, absy2_q;
  cqr_pkg::flags_t  flags_q;
  logic [2*DW:0]    disc_q;

  assign x = x_i;
  assign y = y_i;
  assign z = z_i;

  assign absx = x[DW-1] ? DW'(-x) : DW'(x);
  assign absy = y[DW-1] ? DW'(-y) : DW'(y);
  assign absz = z[DW-1] ? DW'(-z) : DW'(z);
  assign prod = x * y;
  assign b2_d = (2*DW)'(absy) * (2*DW)'(absy);
  assign p_d  = (2*DW)'(absx) * (2*DW)'(absz);

  always_comb begin
    case (op_i)
      cqr_pkg::OP_ADD: int_res_d = DW'(x + y);
      cqr_pkg::OP_SUB: int_res_d = DW'(x - y);
      cqr_pkg::OP_MUL: int_res_d = prod[DW-1:0];
      default:         int_res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q    <= op_i;
      res1_q   <= int_res_d;
      y1_q     <= y_i;
      absx1_q  <= absx;
      absy1_q  <= absy;
      xneg1_q  <= x[DW-1];
      yneg1_q  <= y[DW-1];
      acneg1_q <= x[DW-1] ^ z[DW-1];
      b2_q     <= b2_d;
      p_q      <= p_d;
    end
  end

  assign four_p = {p_q, 2'b00};
  assign b2w    = (2*DW+2)'(b2_q);

  always_comb begin
    dsum   = '0;
    pos_d  = 1'b0;
    zero_d = 1'b0;
    if (op1_q == cqr_pkg::OP_ROOTS && absx1_q != '0) begin
      if (acneg1_q && p_q != '0) begin
        dsum  = b2w + four_p;
        pos_d = 1'b1;
      end else if (four_p <= b2w) begin
        dsum   = b2w - four_p;
        pos_d  = 1'b1;
        zero_d = (dsum == '0);
      end
    end
  end

  always_comb begin
    flags_d.x_neg     = xneg1_q;
    flags_d.y_neg     = yneg1_q;
    flags_d.y_zero    = (absy1_q == '0);
    flags_d.a_zero    = (absx1_q == '0);
    flags_d.disc_pos  = pos_d;
    flags_d.disc_zero = zero_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op2_q   <= op1_q;
      res2_q  <= res1_q;
      y2_q    <= y1_q;
      absx2_q <= absx1_q;
      absy2_q <= absy1_q;
      flags_q <= flags_d;
      disc_q  <= dsum[2*DW:0];
    end
  end

  assign valid_o   = v2_q;
  assign op_o      = op2_q;
  assign int_res_o = res2_q;
  assign flags_o   = flags_q;
  assign y_o       = y2_q;
  assign absx_o    = absx2_q;
  assign absy_o    = absy2_q;
  assign disc_o    = disc_q;

endmodule

>>> rtl/cqr_sqrt.sv
// ----------------------------------------------------------------------------
// cqr_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module cqr_sqrt #(
  parameter int unsigned SW     = 33,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2*SW-1:0]     rad_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [SW-1:0]       root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int unsigned RW = SW + 3;

  logic              v_q    [SW];
  logic [RW-1:0]     rem_q  [SW];
  logic [SW-1:0]     root_q [SW];
  logic [2*SW-1:0]   rad_q  [SW];
  logic [SIDE_W-1:0] side_q [SW];

  for (genvar i = 0; i < SW; i++) begin : g_stage
    logic              v_in;
    logic [RW-1:0]     rem_in, rem_sh, trial, rem_d;
    logic [SW-1:0]     root_in, root_d;
    logic [2*SW-1:0]   rad_in;
    logic [SIDE_W-1:0] side_in;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign side_in = side_q[i-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {rem_in[RW-3:0], rad_in[2*SW-1:2*SW-2]};
    assign trial  = RW'({root_in, 2'b01});
    assign ge     = (rem_sh >= trial);
    assign rem_d  = ge ? rem_sh - trial : rem_sh;
    assign root_d = {root_in[SW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_d;
        root_q[i] <= root_d;
        rad_q[i]  <= {rad_in[2*SW-3:0], 2'b00};
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = v_q[SW-1];
  assign root_o  = root_q[SW-1];
  assign side_o  = side_q[SW-1];

endmodule

>>> rtl/cqr_div.sv
// ----------------------------------------------------------------------------
// cqr_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cqr_div #(
  parameter int unsigned NW     = 50,
  parameter int unsigned DENW   = 33,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [NW-1:0]       num_i,
  input  logic [DENW-1:0]     den_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [NW-1:0]       quot_o,
  output logic [SIDE_W-1:0]   side_o
);

  logic              v_q    [NW];
  logic [DENW-1:0]   rem_q  [NW];
  logic [NW-1:0]     quot_q [NW];
  logic [NW-1:0]     num_q  [NW];
  logic [DENW-1:0]   den_q  [NW];
  logic [SIDE_W-1:0] side_q [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic              v_in;
    logic [DENW-1:0]   rem_in, den_in;
    logic [DENW:0]     rem_sh, rem_sub;
    logic [NW-1:0]     quot_in, num_in;
    logic [SIDE_W-1:0] side_in;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign quot_in = '0;
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign quot_in = quot_q[i-1];
      assign num_in  = num_q[i-1];
      assign den_in  = den_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign rem_sh  = {rem_in, num_in[NW-1]};
    assign ge      = (rem_sh >= {1'b0, den_in});
    assign rem_sub = rem_sh - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? rem_sub[DENW-1:0] : rem_sh[DENW-1:0];
        quot_q[i] <= {quot_in[NW-2:0], ge};
        num_q[i]  <= {num_in[NW-2:0], 1'b0};
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quot_o  = quot_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

>>> rtl/calculator_with_quadratic_roots_unit.sv
// ----------------------------------------------------------------------------
// calculator_with_quadratic_roots_unit
// Integer add/sub/mul/div and fixed-point quadratic roots, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_stall_o opcode, operand_first/second/third
//  out      output     out_valid_o/ out_stall_i first_value, second_value,
//                                               root_count, status
//
//  one transaction enters per cycle while the output is not stalled; the stages in order are
//  two front stages, one square root stage per root bit,
//  one operand stage, one divider stage per numerator bit, and the output register
//  reset clears only the valid bits; no clearing pass
//  a stalled output freezes the whole pipeline; in_stall_o follows it directly
// ----------------------------------------------------------------------------
module calculator_with_quadratic_roots_unit #(
  parameter int unsigned DATA_WIDTH    = cqr_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = cqr_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [cqr_pkg::OP_WIDTH-1:0]        opcode_i,
  input  logic signed [cqr_pkg::PORT_WIDTH-1:0] operand_first_i,
  input  logic signed [cqr_pkg::PORT_WIDTH-1:0] operand_second_i,
  input  logic signed [cqr_pkg::PORT_WIDTH-1:0] operand_third_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cqr_pkg::PORT_WIDTH-1:0] first_value_o,
  output logic signed [cqr_pkg::PORT_WIDTH-1:0] second_value_o,
  output logic [1:0]                          root_count_o,
  output logic [1:0]                          status_o
);

  localparam int unsigned DW     = DATA_WIDTH;
  localparam int unsigned FB     = FRACTION_BITS;
  localparam int unsigned OPW    = cqr_pkg::OP_WIDTH;
  localparam int unsigned FLW    = cqr_pkg::FLAGS_W;
  localparam int unsigned SW     = DW + 1;
  localparam int unsigned MW     = DW + 2;
  localparam int unsigned NW     = MW + FB;
  localparam int unsigned DENW   = DW + 1;
  localparam int unsigned SQ_SW  = OPW + DW + FLW + 3 * DW;
  localparam int unsigned DA_SW  = OPW + DW + FLW + 1;
  localparam logic [NW-1:0] MAG_MAX = NW'(1) << (DW - 1);

  logic en;

  // front outputs
  logic                f_valid;
  logic [OPW-1:0]      f_op;
  logic [DW-1:0]       f_res, f_y, f_absx, f_absy;
  cqr_pkg::flags_t     f_flags;
  logic [2*DW:0]       f_disc;

  // square root outputs
  logic                s_valid;
  logic [SW-1:0]       s_root;
  logic [SQ_SW-1:0]    s_side;
  logic [OPW-1:0]      s_op;
  logic [DW-1:0]       s_res, s_y, s_absx, s_absy;
  cqr_pkg::flags_t     s_flags;

  // operand stage
  logic signed [DW+2:0] ys, rs, n1, n2;
  logic [DW+2:0]        n1_mag, n2_mag;
  logic [NW-1:0]        num_a_d, num_b_d;
  logic [DENW-1:0]      den_d;
  logic                 neg_a_d, neg_b_d;
  logic                 v3_q;
  logic [NW-1:0]        num_a_q, num_b_q;
  logic [DENW-1:0]      den_q;
  logic [DA_SW-1:0]     side_a_q;
  logic                 neg_b_q;

  // divider outputs
  logic                 da_valid, db_valid;
  logic [NW-1:0]        qa, qb;
  logic [DA_SW-1:0]     da_side;
  logic                 db_side;
  logic [OPW-1:0]       d_op;
  logic [DW-1:0]        d_res;
  cqr_pkg::flags_t      d_flags;
  logic                 d_neg_a;

  // output stage
  logic signed [DW-1:0] r1_d, r2_d, root1, root2, qint;
  logic                 sat1, sat2;
  logic [1:0]           cnt_d, st_d;
  logic                 out_v_q;
  logic signed [DW-1:0] r1_q, r2_q;
  logic [1:0]           cnt_q, st_q;

  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = out_v_q && out_stall_i;

  cqr_front #(
    .DW (DW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .op_i      (opcode_i),
    .x_i       (operand_first_i[DW-1:0]),
    .y_i       (operand_second_i[DW-1:0]),
    .z_i       (operand_third_i[DW-1:0]),
    .valid_o   (f_valid),
    .op_o      (f_op),
    .int_res_o (f_res),
    .flags_o   (f_flags),
    .y_o       (f_y),
    .absx_o    (f_absx),
    .absy_o    (f_absy),
    .disc_o    (f_disc)
  );

  cqr_sqrt #(
    .SW     (SW),
    .SIDE_W (SQ_SW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .rad_i   ((2*SW)'(f_disc)),
    .side_i  ({f_op, f_res, f_flags, f_y, f_absx, f_absy}),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  assign {s_op, s_res, s_flags, s_y, s_absx, s_absy} = s_side;

  // numerators -b +/- s, and the integer divide operands
  assign ys     = (DW+3)'(signed'(s_y));
  assign rs     = signed'((DW+3)'(s_root));
  assign n1     = rs - ys;
  assign n2     = -ys - rs;
  assign n1_mag = n1[DW+2] ? (DW+3)'(-n1) : (DW+3)'(n1);
  assign n2_mag = n2[DW+2] ? (DW+3)'(-n2) : (DW+3)'(n2);

  always_comb begin
    if (s_op == cqr_pkg::OP_ROOTS) begin
      num_a_d = {n1_mag[MW-1:0], FB'(0)};
      num_b_d = {n2_mag[MW-1:0], FB'(0)};
      den_d   = {s_absx, 1'b0};
      neg_a_d = n1[DW+2] ^ s_flags.x_neg;
      neg_b_d = n2[DW+2] ^ s_flags.x_neg;
    end else begin
      num_a_d = NW'(s_absx);
      num_b_d = '0;
      den_d   = DENW'(s_absy);
      neg_a_d = s_flags.x_neg ^ s_flags.y_neg;
      neg_b_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= s_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_a_q  <= num_a_d;
      num_b_q  <= num_b_d;
      den_q    <= den_d;
      side_a_q <= {s_op, s_res, s_flags, neg_a_d};
      neg_b_q  <= neg_b_d;
    end
  end

  cqr_div #(
    .NW     (NW),
    .DENW   (DENW),
    .SIDE_W (DA_SW)
  ) u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (num_a_q),
    .den_i   (den_q),
    .side_i  (side_a_q),
    .valid_o (da_valid),
    .quot_o  (qa),
    .side_o  (da_side)
  );

  cqr_div #(
    .NW     (NW),
    .DENW   (DENW),
    .SIDE_W (1)
  ) u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (num_b_q),
    .den_i   (den_q),
    .side_i  (neg_b_q),
    .valid_o (db_valid),
    .quot_o  (qb),
    .side_o  (db_side)
  );

  assign {d_op, d_res, d_flags, d_neg_a} = da_side;

  // saturate each root magnitude into the signed range
  always_comb begin
    sat1  = d_neg_a ? (qa > MAG_MAX) : (qa >= MAG_MAX);
    sat2  = db_side ? (qb > MAG_MAX) : (qb >= MAG_MAX);
    root1 = sat1 ? (d_neg_a ? signed'(DW'(MAG_MAX)) : signed'(DW'(MAG_MAX - 1'b1)))
                 : (d_neg_a ? signed'(DW'(-qa[DW-1:0])) : signed'(qa[DW-1:0]));
    root2 = sat2 ? (db_side ? signed'(DW'(MAG_MAX)) : signed'(DW'(MAG_MAX - 1'b1)))
                 : (db_side ? signed'(DW'(-qb[DW-1:0])) : signed'(qb[DW-1:0]));
    qint  = d_neg_a ? signed'(DW'(-qa[DW-1:0])) : signed'(qa[DW-1:0]);
  end

  always_comb begin
    r1_d  = '0;
    r2_d  = '0;
    cnt_d = cqr_pkg::CNT_NONE;
    st_d  = cqr_pkg::ST_OK;
    case (d_op)
      cqr_pkg::OP_ADD, cqr_pkg::OP_SUB, cqr_pkg::OP_MUL: begin
        r1_d = d_res;
      end
      cqr_pkg::OP_DIV: begin
        if (d_flags.y_zero) begin
          st_d = cqr_pkg::ST_DIV_ZERO;
        end else begin
          r1_d = qint;
          if (!d_neg_a && qa == MAG_MAX) begin
            st_d = cqr_pkg::ST_OVERFLOW;
          end
        end
      end
      cqr_pkg::OP_ROOTS: begin
        if (d_flags.a_zero) begin
          st_d = cqr_pkg::ST_DIV_ZERO;
        end else if (d_flags.disc_pos) begin
          r1_d = root1;
          if (d_flags.disc_zero) begin
            cnt_d = cqr_pkg::CNT_DOUBLE;
            if (sat1) st_d = cqr_pkg::ST_OVERFLOW;
          end else begin
            r2_d  = root2;
            cnt_d = cqr_pkg::CNT_DISTINCT;
            if (sat1 || sat2) st_d = cqr_pkg::ST_OVERFLOW;
          end
        end
      end
      default: begin
        r1_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= da_valid && db_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q  <= r1_d;
      r2_q  <= r2_d;
      cnt_q <= cnt_d;
      st_q  <= st_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign first_value_o  = cqr_pkg::PORT_WIDTH'(r1_q);
  assign second_value_o = cqr_pkg::PORT_WIDTH'(r2_q);
  assign root_count_o   = cnt_q;
  assign status_o       = st_q;

endmodule
